### rtl/core/dwns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwns_pkg
// Shared constants, item types and a helper for the daily window slot finder.
// ----------------------------------------------------------------------------
package dwns_pkg;

	localparam int DAY_SEC     = 86400;
	localparam int MIN_PER_DAY = 1440;
	localparam int TZ_LIMIT    = 14 * 60;
	localparam int SEC_PER_MIN = 60;
	localparam int IV_RESET    = 60;

	localparam int CFG_W  = 11;
	localparam int ADDR_W = 4;
	localparam int SEC_W  = 17;
	localparam int CALC_W = 21;
	localparam int X_W    = 19;
	localparam int LIM_W  = 20;
	localparam int DELTA_W = 18;

	localparam int DAY_CELLS = 16;
	localparam int DAY_W     = 33;
	localparam logic [DAY_W-1:0] DAY_DIV = DAY_W'(DAY_SEC) << (DAY_CELLS - 1);

	localparam int SLOT_CELLS = 12;
	localparam int SLOT_W     = 29;
	localparam int LANES      = 3;

	localparam int PIPE_DEPTH = DAY_CELLS + SLOT_CELLS + 4;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

	localparam logic signed [CFG_W-1:0] TZ_MAX = CFG_W'(TZ_LIMIT);
	localparam logic signed [CFG_W-1:0] TZ_MIN = -TZ_MAX;

	typedef enum logic [1:0] {
		REG_START,
		REG_END,
		REG_INTERVAL,
		REG_TZ
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]      now;
		logic             neg;
		logic [DAY_W-1:0] val;
	} day_item_t;

	typedef struct packed {
		logic [31:0]                   now;
		logic [LANES-1:0][SLOT_W-1:0] val;
		logic [LANES-1:0][X_W-1:0]    x;
		logic [LANES-1:0][LIM_W-1:0]  lim;
	} slot_item_t;

	function automatic logic [SEC_W-1:0] sec_of_min(input logic [CFG_W-1:0] m);
		logic [SEC_W-1:0] w;
		w = {{(SEC_W-CFG_W){1'b0}}, m};
		return w * SEC_W'(SEC_PER_MIN);
	endfunction

endpackage

### rtl/core/daily_window_next_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_window_next_slot
// Next measurement time inside a configurable daily window.
//
// Each request carries a UTC epoch time; the block answers with the earliest
// slot of the local daily window that is not earlier than that time, as UTC
// epoch seconds modulo 2^32, or 0 with disabled set when the interval is zero.
// One request is taken per clock unless back-pressure from the output reaches
// the input, and each result passes through 16 cells of the chain that finds
// the local second of day (one quotient bit each), 12 cells of the chain that
// finds the offset to the next slot for yesterday's, today's and tomorrow's
// window in parallel, and four stage registers around them.
// Stalls on the output fill bubbles first, so requests keep being taken
// until all 32 stages hold an item. Registers sit on an APB port at 0x0
// (start minute), 0x4 (end minute), 0x8 (interval), 0xC (time zone offset);
// values out of range are dropped. Change them only with no request in flight.
// ----------------------------------------------------------------------------
module daily_window_next_slot import dwns_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              query_valid,
	output logic              query_ready,
	input  logic [31:0]       now_seconds,
	output logic              slot_valid,
	input  logic              slot_ready,
	output logic [31:0]       next_seconds,
	output logic              disabled
);

	// configuration
	reg_idx_t          reg_idx;
	logic [CFG_W-1:0]  wval;
	logic              cfg_write;
	logic [CFG_W-1:0]  start_q;
	logic [CFG_W-1:0]  end_q;
	logic [CFG_W-1:0]  iv_q;
	logic [CFG_W-1:0]  tz_q;

	logic [SEC_W-1:0]        iv_sec;
	logic [SEC_W-1:0]        start_sec;
	logic [SEC_W-1:0]        end_sec;
	logic signed [SEC_W-1:0] tz_ext;
	logic signed [SEC_W-1:0] tz_sec;
	logic                    all_day;
	logic                    wraps;
	logic [SLOT_W-1:0]       div;

	assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wval      = pwdata[CFG_W-1:0];
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			iv_q    <= CFG_W'(IV_RESET);
			tz_q    <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_START: begin
					if (wval < CFG_W'(MIN_PER_DAY)) begin
						start_q <= wval;
					end
				end
				REG_END: begin
					if (wval < CFG_W'(MIN_PER_DAY)) begin
						end_q <= wval;
					end
				end
				REG_INTERVAL: begin
					if (wval <= CFG_W'(MIN_PER_DAY)) begin
						iv_q <= wval;
					end
				end
				REG_TZ: begin
					if ($signed(wval) >= TZ_MIN && $signed(wval) <= TZ_MAX) begin
						tz_q <= wval;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START:    prdata = {{(32-CFG_W){1'b0}}, start_q};
			REG_END:      prdata = {{(32-CFG_W){1'b0}}, end_q};
			REG_INTERVAL: prdata = {{(32-CFG_W){1'b0}}, iv_q};
			REG_TZ:       prdata = {{(32-CFG_W){tz_q[CFG_W-1]}}, tz_q};
			default:      prdata = '0;
		endcase
	end

	assign iv_sec    = sec_of_min(iv_q);
	assign start_sec = sec_of_min(start_q);
	assign end_sec   = sec_of_min(end_q);
	assign tz_ext    = $signed({{(SEC_W-CFG_W){tz_q[CFG_W-1]}}, tz_q});
	assign tz_sec    = tz_ext * $signed(SEC_W'(SEC_PER_MIN));
	assign all_day   = (start_q == end_q);
	assign wraps     = (end_q < start_q);
	assign div       = SLOT_W'({iv_sec, {(SLOT_CELLS-1){1'b0}}});

	// stage 1: local time, folded to a non-negative value
	logic signed [33:0] local_c;
	logic signed [33:0] local_adj;
	day_item_t          entry_c;
	logic               v_s1;
	day_item_t          item_s1;
	logic               s1_ready;

	always_comb begin
		local_c   = $signed({2'b00, now_seconds}) + 34'(tz_sec);
		local_adj = local_c + 34'(DAY_SEC);
		entry_c.now = now_seconds;
		entry_c.neg = local_c[33];
		entry_c.val = local_c[33] ? DAY_W'(local_adj) : DAY_W'(local_c);
	end

	// day remainder chain
	logic      day_v [DAY_CELLS+1];
	logic      day_r [DAY_CELLS+1];
	day_item_t day_it [DAY_CELLS+1];

	assign s1_ready    = !v_s1 || day_r[0];
	assign query_ready = s1_ready;

	assign day_v[0]  = v_s1;
	assign day_it[0] = item_s1;

	for (genvar g = 0; g < DAY_CELLS; g++) begin : g_day
		dwns_day_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (day_v[g]),
			.up_ready (day_r[g]),
			.up_item  (day_it[g]),
			.dn_valid (day_v[g+1]),
			.dn_ready (day_r[g+1]),
			.dn_item  (day_it[g+1])
		);
	end

	// stage 2: offsets of the three windows from now
	slot_item_t prep_c;
	logic       v_s2;
	slot_item_t item_s2;
	logic       s2_ready;

	always_comb begin
		logic [CALC_W-1:0] r_c;
		logic [CALC_W-1:0] off_c;
		logic [CALC_W-1:0] ws_c;
		logic [CALC_W-1:0] we_c;
		logic [X_W-1:0]    x_c;
		prep_c = '0;
		prep_c.now = day_it[DAY_CELLS].now;
		r_c = CALC_W'(day_it[DAY_CELLS].val[DAY_W-1 -: SEC_W])
			- (day_it[DAY_CELLS].neg ? CALC_W'(DAY_SEC) : CALC_W'(0));
		for (int i = 0; i < LANES; i++) begin
			off_c = CALC_W'(i * DAY_SEC) - CALC_W'(DAY_SEC);
			ws_c  = off_c + CALC_W'(start_sec);
			if (all_day) begin
				we_c = ws_c + CALC_W'(DAY_SEC);
			end else if (wraps) begin
				we_c = CALC_W'(i * DAY_SEC) + CALC_W'(end_sec);
			end else begin
				we_c = off_c + CALC_W'(end_sec);
			end
			x_c = X_W'(r_c - ws_c);
			prep_c.x[i]   = x_c;
			prep_c.lim[i] = LIM_W'(we_c - r_c);
			prep_c.val[i] = x_c[X_W-1] ? '0 : SLOT_W'(x_c[X_W-2:0]);
		end
	end

	// slot remainder chain
	logic       slot_v [SLOT_CELLS+1];
	logic       slot_r [SLOT_CELLS+1];
	slot_item_t slot_it [SLOT_CELLS+1];

	assign s2_ready              = !v_s2 || slot_r[0];
	assign day_r[DAY_CELLS]      = s2_ready;

	assign slot_v[0]  = v_s2;
	assign slot_it[0] = item_s2;

	for (genvar g = 0; g < SLOT_CELLS; g++) begin : g_slot
		dwns_slot_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.div      (div),
			.up_valid (slot_v[g]),
			.up_ready (slot_r[g]),
			.up_item  (slot_it[g]),
			.dn_valid (slot_v[g+1]),
			.dn_ready (slot_r[g+1]),
			.dn_item  (slot_it[g+1])
		);
	end

	// stage 3: distance to the slot and window check per lane
	logic [LANES-1:0][DELTA_W-1:0] delta_c;
	logic [LANES-1:0]              found_c;
	logic                          v_s3;
	logic [31:0]                   now_s3;
	logic [LANES-1:0][DELTA_W-1:0] delta_s3;
	logic [LANES-1:0]              found_s3;
	logic                          s3_ready;

	always_comb begin
		logic [SEC_W-1:0]   rem_c;
		logic [X_W-1:0]     x_c;
		logic [LIM_W-1:0]   lim_c;
		logic [LIM_W-2:0]   d_c;
		for (int i = 0; i < LANES; i++) begin
			rem_c = slot_it[SLOT_CELLS].val[i][SLOT_W-1 -: SEC_W];
			x_c   = slot_it[SLOT_CELLS].x[i];
			lim_c = slot_it[SLOT_CELLS].lim[i];
			if (x_c[X_W-1]) begin
				delta_c[i] = DELTA_W'(X_W'(0) - x_c);
			end else if (rem_c != '0) begin
				delta_c[i] = DELTA_W'(iv_sec - rem_c);
			end else begin
				delta_c[i] = '0;
			end
			d_c = (LIM_W-1)'(delta_c[i]);
			found_c[i] = !lim_c[LIM_W-1]
				&& ((d_c < lim_c[LIM_W-2:0]) || (d_c == lim_c[LIM_W-2:0] && !all_day));
		end
	end

	// stage 4: earliest window wins; output register
	logic        v_s4;
	logic [31:0] next_s4;
	logic        dis_s4;
	logic        s4_ready;
	logic [31:0] next_c;
	logic        dis_c;

	assign s3_ready               = !v_s3 || s4_ready;
	assign slot_r[SLOT_CELLS]     = s3_ready;

	always_comb begin
		logic [DELTA_W-1:0] sel_c;
		logic               hit_c;
		sel_c = '0;
		hit_c = 1'b0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (found_s3[i]) begin
				sel_c = delta_s3[i];
				hit_c = 1'b1;
			end
		end
		next_c = hit_c ? now_s3 + 32'(sel_c) : '0;
		dis_c  = 1'b0;
		if (iv_q == '0) begin
			next_c = '0;
			dis_c  = 1'b1;
		end
	end

	assign s4_ready     = !v_s4 || slot_ready;
	assign slot_valid   = v_s4;
	assign next_seconds = next_s4;
	assign disabled     = dis_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= query_valid;
			end
			if (s2_ready) begin
				v_s2 <= day_v[DAY_CELLS];
			end
			if (s3_ready) begin
				v_s3 <= slot_v[SLOT_CELLS];
			end
			if (s4_ready) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_valid && s1_ready) begin
			item_s1 <= entry_c;
		end
		if (day_v[DAY_CELLS] && s2_ready) begin
			item_s2 <= prep_c;
		end
		if (slot_v[SLOT_CELLS] && s3_ready) begin
			now_s3   <= slot_it[SLOT_CELLS].now;
			delta_s3 <= delta_c;
			found_s3 <= found_c;
		end
		if (v_s3 && s4_ready) begin
			next_s4 <= next_c;
			dis_s4  <= dis_c;
		end
	end

endmodule

### rtl/core/dwns_day_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwns_day_cell
// One restoring step of the seconds-of-day remainder: compare, subtract, shift.
// ----------------------------------------------------------------------------
module dwns_day_cell import dwns_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  day_item_t up_item,
	output logic      dn_valid,
	input  logic      dn_ready,
	output day_item_t dn_item
);

	logic             valid_q;
	day_item_t        item_q;
	day_item_t        nxt;
	logic [DAY_W-1:0] diff;

	always_comb begin
		nxt = up_item;
		diff = (up_item.val >= DAY_DIV) ? up_item.val - DAY_DIV : up_item.val;
		nxt.val = {diff[DAY_W-2:0], 1'b0};
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule

### rtl/core/dwns_slot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwns_slot_cell
// One restoring step of the slot remainder, three window lanes side by side.
// ----------------------------------------------------------------------------
module dwns_slot_cell import dwns_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] div,
	input  logic              up_valid,
	output logic              up_ready,
	input  slot_item_t        up_item,
	output logic              dn_valid,
	input  logic              dn_ready,
	output slot_item_t        dn_item
);

	logic       valid_q;
	slot_item_t item_q;
	slot_item_t nxt;

	always_comb begin
		logic [SLOT_W-1:0] diff;
		nxt = up_item;
		for (int i = 0; i < LANES; i++) begin
			diff = (up_item.val[i] >= div) ? up_item.val[i] - div : up_item.val[i];
			nxt.val[i] = {diff[SLOT_W-2:0], 1'b0};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule

### rtl/core/dwns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwns_checker
// Port-level checks on the slot finder: request bookkeeping and result rules.
// ----------------------------------------------------------------------------
module dwns_checker import dwns_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        query_valid,
	input logic        query_ready,
	input logic        slot_valid,
	input logic        slot_ready,
	input logic [31:0] next_seconds,
	input logic        disabled
);

	logic [CNT_W-1:0] pend_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = query_valid && query_ready;
	assign out_acc = slot_valid && slot_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		slot_valid && !slot_ready |=> slot_valid && $stable(next_seconds) && $stable(disabled))
		else $error("result changed while stalled");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		slot_valid |-> pend_q != '0)
		else $error("result without pending request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(PIPE_DEPTH))
		else $error("more requests in flight than stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == '0 |-> query_ready)
		else $error("empty pipeline refuses a request");

	a_dis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		slot_valid && disabled |-> next_seconds == '0)
		else $error("disabled result with nonzero time");

endmodule

bind daily_window_next_slot dwns_checker u_dwns_checker (.*);

### tb/daily_window_next_slot_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_window_next_slot_tb
// Self-checking bench for the daily window slot finder.
//
// Requests carry epoch times and go in with random gaps. Results are taken
// with random stalls. Each result is compared with a slot that the bench
// works out from its own copy of the window registers. The registers see
// extreme, random and out-of-range writes, and are read back after them.
// ----------------------------------------------------------------------------
module daily_window_next_slot_tb;
	import dwns_pkg::*;

	typedef struct {
		logic [31:0] secs;
		logic        dis;
	} slot_t;

	class slot_tracker;
		int unsigned open_min;
		int unsigned end_min;
		int unsigned iv_min;
		int          tz_min;
		int          errors;
		slot_t       expected_slots[$];

		function new();
			open_min  = 0;
			end_min   = 0;
			iv_min    = 60;
			tz_min    = 0;
			errors    = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) $display("%0t ERROR: %s", $time, msg);
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] value);
			logic [10:0] v;
			int          s;
			v = value[10:0];
			s = v[10] ? int'(v) - 2048 : int'(v);
			case (r)
				REG_START:    if (v < 1440) open_min = v;
				REG_END:      if (v < 1440) end_min = v;
				REG_INTERVAL: if (v <= 1440) iv_min = v;
				default:      if (s >= -840 && s <= 840) tz_min = s;
			endcase
		endfunction

		function logic [10:0] reg_bits(reg_idx_t r);
			case (r)
				REG_START:    return 11'(open_min);
				REG_END:      return 11'(end_min);
				REG_INTERVAL: return 11'(iv_min);
				default:      return 11'(tz_min);
			endcase
		endfunction

		// earliest slot not before now: yesterday's, today's, tomorrow's window
		function slot_t predict_slot(logic [31:0] now);
			slot_t  r;
			longint tz_s, iv, loc, day0, st, en, ws, we, slot;
			r.secs = '0;
			r.dis  = 1'b0;
			if (iv_min == 0) begin
				r.dis = 1'b1;
				return r;
			end
			tz_s = longint'(tz_min) * 60;
			iv   = longint'(iv_min) * 60;
			loc  = longint'({32'h0, now}) + tz_s;
			day0 = loc - (loc % longint'(86400));
			st   = longint'(open_min) * 60;
			en   = longint'(end_min) * 60;
			for (int d = -1; d <= 1; d++) begin
				ws = day0 + longint'(d) * 86400 + st;
				if (st == en)
					we = ws + 86400;
				else if (en > st)
					we = day0 + longint'(d) * 86400 + en;
				else
					we = day0 + longint'(d + 1) * 86400 + en;
				if (loc < ws)
					slot = ws;
				else
					slot = ws + ((loc - ws + iv - 1) / iv) * iv;
				if (slot < we || (slot == we && st != en)) begin
					r.secs = 32'(slot - tz_s);
					return r;
				end
			end
			return r;
		endfunction

		function void note_query(logic [31:0] now);
			expected_slots.push_back(predict_slot(now));
		endfunction

		function void check_slot(logic [31:0] secs, logic dis);
			slot_t e;
			if (expected_slots.size() == 0) begin
				report($sformatf("result %0d/%b with no request pending", secs, dis));
				return;
			end
			e = expected_slots.pop_front();
			if (secs !== e.secs)
				report($sformatf("next_seconds exp %0d got %0d", e.secs, secs));
			if (dis !== e.dis)
				report($sformatf("disabled exp %b got %b", e.dis, dis));
		endfunction

		function int pending();
			return expected_slots.size();
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [ADDR_W-1:0] paddr       = '0;
	logic [31:0]       pwdata      = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              query_valid = 1'b0;
	logic              query_ready;
	logic [31:0]       now_seconds = '0;
	logic              slot_valid;
	logic              slot_ready  = 1'b0;
	logic [31:0]       next_seconds;
	logic              disabled;

	slot_tracker sb;
	bit          calm       = 1'b0;
	int          stall_left = 0;

	daily_window_next_slot i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.now_seconds (now_seconds),
		.slot_valid  (slot_valid),
		.slot_ready  (slot_ready),
		.next_seconds(next_seconds),
		.disabled    (disabled)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int unsigned k;
		if (calm) return 0;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			slot_ready = 1'b0;
			stall_left--;
		end else begin
			slot_ready = 1'b1;
			if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && slot_valid && slot_ready) sb.check_slot(next_seconds, disabled);
	end

	// all tasks below start and end at a falling edge
	task automatic send_query(logic [31:0] now);
		int g;
		g = pick_gap();
		if (g > 0) begin
			query_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		query_valid = 1'b1;
		now_seconds = now;
		@(posedge clk);
		while (!query_ready) @(posedge clk);
		sb.note_query(now);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		query_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [10:0] v);
		logic [31:0] w;
		w = {21'h0, v};
		if ($urandom_range(0, 3) == 0) w[31:11] = 21'($urandom);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_W'({r, 2'b00});
		pwdata  = w;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(r, w);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic read_check(reg_idx_t r);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = ADDR_W'({r, 2'b00});
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[10:0] !== sb.reg_bits(r))
			sb.report($sformatf("%s reads %h, exp %h", r.name(), prdata[10:0],
				sb.reg_bits(r)));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_regs();
		for (int i = 0; i < 4; i++) read_check(reg_idx_t'(i));
	endtask

	task automatic set_cfg(int unsigned s, int unsigned e, int unsigned iv, int tz);
		write_reg(REG_START, 11'(s));
		write_reg(REG_END, 11'(e));
		write_reg(REG_INTERVAL, 11'(iv));
		write_reg(REG_TZ, 11'(tz));
		check_regs();
	endtask

	task automatic bad_write(reg_idx_t r);
		case (r)
			REG_START, REG_END: write_reg(r, 11'($urandom_range(1440, 2047)));
			REG_INTERVAL:       write_reg(r, 11'($urandom_range(1441, 2047)));
			default:            write_reg(r, 11'($urandom_range(841, 1207)));
		endcase
		read_check(r);
	endtask

	task automatic random_cfg();
		int unsigned s, e, iv, k;
		int          tz;
		k = $urandom_range(0, 4);
		s = (k == 0) ? 0 : (k == 1) ? 1439 : $urandom_range(0, 1439);
		k = $urandom_range(0, 19);
		e = (k < 5) ? s : (k < 7) ? 0 : (k < 9) ? 1439 : $urandom_range(0, 1439);
		k = $urandom_range(0, 49);
		iv = (k < 3) ? 0 : (k < 8) ? 1440 : (k < 13) ? 1 : $urandom_range(1, 1440);
		k = $urandom_range(0, 19);
		tz = (k < 3) ? -840 : (k < 6) ? 840 : int'($urandom_range(0, 1680)) - 840;
		set_cfg(s, e, iv, tz);
		if ($urandom_range(0, 9) < 4) bad_write(reg_idx_t'($urandom_range(0, 3)));
	endtask

	// times near window edges and slot boundaries, near both ends of the range, or random
	function automatic logic [31:0] pick_now();
		int unsigned k;
		longint      t;
		k = $urandom_range(0, 9);
		if (k < 3) return $urandom;
		if (k == 3) return $urandom_range(0, 200000);
		if (k == 4) return 32'hFFFF_FFFF - $urandom_range(0, 200000);
		t = longint'($urandom_range(0, 49710)) * 86400 - longint'(sb.tz_min) * 60;
		case ($urandom_range(0, 2))
			0:       t += longint'(sb.open_min) * 60
				+ longint'(sb.iv_min) * 60 * longint'($urandom_range(0, 30));
			1:       t += longint'(sb.end_min) * 60;
			default: t += longint'($urandom_range(0, 86399));
		endcase
		t += longint'($urandom_range(0, 6)) - 3;
		return 32'(t);
	endfunction

	initial begin
		sb = new();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		check_regs();

		// all-day window from reset, wrap at the top of the range
		send_query(32'd0);
		send_query(32'd3600);
		send_query(32'd3601);
		send_query(32'd86399);
		send_query(32'hFFFF_FFFF);
		send_query(32'h8000_0000);
		wait_idle();

		// across midnight, negative local time
		set_cfg(1439, 0, 1, -840);
		send_query(32'd0);
		send_query(32'd50400);
		send_query(32'd86399);
		send_query(32'hFFFF_FFFF);
		wait_idle();

		// all-day window, slot on the end is excluded
		set_cfg(1439, 1439, 1440, 840);
		send_query(32'd35940);
		send_query(32'd35941);
		send_query(32'hFFFF_FFFF);
		wait_idle();

		// slot on the end of an ordinary window is included
		set_cfg(600, 660, 6, 0);
		send_query(32'd36000);
		send_query(32'd39600);
		send_query(32'd39601);
		wait_idle();

		// disabled
		set_cfg(600, 660, 0, 0);
		send_query(32'h1234_5678);
		send_query(32'hFFFF_FFFF);
		wait_idle();

		// rejected writes keep the old value
		write_reg(REG_START, 11'd1440);
		write_reg(REG_END, 11'd2047);
		write_reg(REG_INTERVAL, 11'd1441);
		write_reg(REG_INTERVAL, 11'd2047);
		write_reg(REG_TZ, 11'd841);
		write_reg(REG_TZ, 11'h4B7);
		write_reg(REG_TZ, 11'h400);
		check_regs();

		for (int p = 0; p < 26; p++) begin
			calm = ($urandom_range(0, 3) == 0);
			random_cfg();
			repeat (50) send_query(pick_now());
			wait_idle();
		end

		calm = 1'b0;
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("daily_window_next_slot_tb: done, clean");
		end else begin
			$display("daily_window_next_slot_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("daily_window_next_slot_tb: done, errors");
		$finish;
	end

endmodule

### filelist.f
rtl/core/dwns_pkg.sv
rtl/core/dwns_day_cell.sv
rtl/core/dwns_slot_cell.sv
rtl/core/daily_window_next_slot.sv
rtl/core/dwns_checker.sv
tb/daily_window_next_slot_tb.sv
